>>> rtl/mipmap_box_downscale_assert.svh
// assertion macros for the box downscaler
`ifndef MIPMAP_BOX_DOWNSCALE_ASSERT_SVH
`define MIPMAP_BOX_DOWNSCALE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbd check failed");

// next-cycle implication, checked outside reset
`define MBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbd check failed");

`endif

>>> rtl/mbd_pkg.sv
package mbd_pkg;

  // configuration and geometry
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CFG_W         = 13;
  localparam int ROW_W         = 12;
  localparam int LANES         = 4;
  localparam int NORM_LANES    = 3;

  // arithmetic widths
  localparam int FIELD_W = 10;
  localparam int SUM_W   = 12;
  localparam int SQ_W    = 16;
  localparam int S_W     = 18;
  localparam int STEP_W  = 3;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_NORMAL   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQ,
    ST_SSUM,
    ST_NA,
    ST_NB,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic       nm;
    logic       right;
    logic       use_mem;
    logic [1:0] shift;
  } avg_ctl_t;

  typedef struct packed {
    logic       load;
    logic       phase_a;
    logic       phase_b;
    logic [7:0] bit_mask;
  } norm_ctl_t;

endpackage

>>> rtl/mbd_avg_lane.sv
module mbd_avg_lane import mbd_pkg::*; (
  input  logic [7:0]         cur,
  input  logic [7:0]         held,
  input  logic [FIELD_W-1:0] stored,
  input  avg_ctl_t           ctl,
  input  logic               enable,
  output logic [FIELD_W-1:0] pair,
  output logic [7:0]         avg
);

  logic signed [FIELD_W-1:0] lin_cur, lin_held;
  logic signed [SUM_W-1:0]   pair_s, stored_s, total, biased, quot, hq, half;

  always_comb begin
    // map to linear domain, normal mode centers on zero and doubles
    lin_cur  = ctl.nm ? {~cur[7], ~cur[7], cur[6:0], 1'b0} : {2'b00, cur};
    lin_held = ctl.nm ? {~held[7], ~held[7], held[6:0], 1'b0} : {2'b00, held};
    pair_s   = SUM_W'(lin_cur) + (ctl.right ? SUM_W'(lin_held) : SUM_W'(0));
    // stored pair sums are signed only in normal mode
    stored_s = ctl.nm ? {{(SUM_W-FIELD_W){stored[FIELD_W-1]}}, stored}
                      : {{(SUM_W-FIELD_W){1'b0}}, stored};
    total    = pair_s + (ctl.use_mem ? stored_s : SUM_W'(0));
    // divide by 1, 2 or 4 truncating toward zero
    biased   = total + (total[SUM_W-1] ? SUM_W'((1 << ctl.shift) - 1) : SUM_W'(0));
    quot     = biased >>> ctl.shift;
    // back to bytes: normal mode takes v/2 truncating toward zero plus 128
    hq       = quot + SUM_W'(quot[SUM_W-1]);
    half     = hq >>> 1;
    pair     = pair_s[FIELD_W-1:0];
    if (!enable) begin
      avg = 8'd0;
    end else if (ctl.nm) begin
      avg = half[7:0] + 8'd128;
    end else begin
      avg = quot[7:0];
    end
  end

endmodule

>>> rtl/mbd_norm_lane.sv
module mbd_norm_lane import mbd_pkg::*; (
  input  logic            clk,
  input  logic [7:0]      avg,
  input  norm_ctl_t       ctl,
  input  logic [S_W-1:0]  s,
  output logic [SQ_W-1:0] sq,
  output logic [7:0]      k
);

  logic signed [9:0]  x, m;
  logic [7:0]         ax, am, cand_n, cand;
  logic signed [17:0] t;
  logic [16:0]        at;
  logic [31:0]        tt;
  logic               xneg, mneg;
  logic [SQ_W-1:0]    mm;
  logic [33:0]        prod;
  logic               fits;

  always_comb begin
    // component and its scaled target 255*x
    x      = signed'({1'b0, avg, 1'b0}) - 10'sd255;
    ax     = x[9] ? 8'(-x) : x[7:0];
    t      = (18'(x) <<< 8) - 18'(x);
    at     = t[17] ? 17'(-t) : t[16:0];
    // candidate odd multiplier 2k-255
    cand_n = k | ctl.bit_mask;
    m      = signed'({1'b0, cand_n, 1'b0}) - 10'sd255;
    am     = m[9] ? 8'(-m) : m[7:0];
    // compare squares, signs decide first
    prod   = 34'(mm) * 34'(s);
    if (mneg) begin
      fits = !xneg || (prod >= 34'(tt));
    end else begin
      fits = !xneg && (prod <= 34'(tt));
    end
  end

  // one search bit per phase_a, phase_b pair
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sq   <= SQ_W'(16'(ax) * 16'(ax));
      tt   <= 32'(34'(at) * 34'(at));
      xneg <= x[9];
      k    <= 8'd0;
    end else if (ctl.phase_a) begin
      mm   <= SQ_W'(16'(am) * 16'(am));
      mneg <= m[9];
      cand <= cand_n;
    end else if (ctl.phase_b && fits) begin
      k    <= cand;
    end
  end

endmodule

>>> rtl/mipmap_box_downscale.sv
// result: m_tvalid is set from ST_LOAD after the bottom-right pixel of a block;
//   normal mode adds ST_SQ, ST_SSUM and an 8-bit search (ST_NA, ST_NB per bit, 3 lanes)
// flow: a new pixel is accepted only in ST_IDLE, so none is taken before the last one
//   is through; a stalled m_tready holds ST_LOAD
// reset: synchronous, restores 1x1 level, four channels, plain mode, counters 0
module mipmap_box_downscale import mbd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,    // chan_a, chan_b, chan_c, chan_d
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,    // out_a, out_b, out_c, out_d
  output logic             m_tlast,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

`include "mipmap_box_downscale_assert.svh"

  localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW        = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int SUM_DEPTH = MAX_WIDTH / 2;
  localparam int AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

  // configuration registers
  logic [CFG_W-1:0] level_width, level_height;
  logic [2:0]       channel_count;
  logic             normal_mode;

  // position and pixel state
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [31:0]      held;
  logic [31:0]      pix;
  state_t           state, state_next;
  logic [STEP_W-1:0] step;

  // per-item flags latched at accept
  logic             store_r, emit_r, last_r;
  avg_ctl_t         actl;
  logic [AW-1:0]    addr_r;
  logic [2:0]       ch_r;
  logic [LANES*FIELD_W-1:0] mem_rd;
  logic [LANES*FIELD_W-1:0] mem [SUM_DEPTH];

  // derived geometry
  logic [WW-1:0]    w_ext, w, nw, col_ext, dx_ext;
  logic [CFG_W-1:0] h, nh, row_ext, dy_ext;
  logic [COL_W-1:0] dx;
  logic [ROW_W-1:0] dy;
  logic [2:0]       ch;
  logic             nm, right, bottom, valid_pos, hold, proc, store, in_acc;
  logic             cfg_hit, col_end, row_end;

  always_comb begin
    w_ext  = WW'(level_width);
    if (w_ext == '0) begin
      w = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = w_ext;
    end
    if (level_height == '0) begin
      h = CFG_W'(1);
    end else if (level_height > CFG_W'(MAX_HEIGHT)) begin
      h = CFG_W'(MAX_HEIGHT);
    end else begin
      h = level_height;
    end
    if (channel_count == 3'd0) begin
      ch = 3'd1;
    end else if (channel_count > 3'd4) begin
      ch = 3'd4;
    end else begin
      ch = channel_count;
    end
    nm      = normal_mode && (ch >= 3'd3);
    nw      = ((w >> 1) == '0) ? WW'(1) : (w >> 1);
    nh      = ((h >> 1) == '0) ? CFG_W'(1) : (h >> 1);
    dx      = col >> 1;
    dy      = row >> 1;
    col_ext = WW'(col);
    dx_ext  = WW'(dx);
    row_ext = CFG_W'(row);
    dy_ext  = CFG_W'(dy);
    right   = w > WW'(1);
    bottom  = h > CFG_W'(1);
    valid_pos = !(!right && !bottom) && (dx_ext < nw) && (dy_ext < nh) &&
                (dx_ext < WW'(SUM_DEPTH));
    hold    = valid_pos && right && !col[0];
    proc    = valid_pos && !hold;
    store   = proc && !row[0] && bottom;
    col_end = (col_ext + WW'(1)) >= w;
    row_end = (row_ext + CFG_W'(1)) >= h;
    in_acc  = s_tvalid && s_tready;
    cfg_hit = cfg_we;
  end

  // configuration writes, any write restarts the level
  always_ff @(posedge clk) begin
    if (rst) begin
      level_width   <= CFG_W'(1);
      level_height  <= CFG_W'(1);
      channel_count <= 3'd4;
      normal_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:    level_width   <= cfg_data;
        REG_HEIGHT:   level_height  <= cfg_data;
        REG_CHANNELS: channel_count <= cfg_data[2:0];
        REG_NORMAL:   normal_mode   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // capture the pixel and its role in the block
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (in_acc && hold) begin
      held <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix          <= s_tdata;
      store_r      <= store;
      emit_r       <= proc && !store;
      last_r       <= (dx_ext == nw - WW'(1)) && (dy_ext == nh - CFG_W'(1));
      addr_r       <= dx[AW-1:0];
      ch_r         <= ch;
      actl.nm      <= nm;
      actl.right   <= right;
      actl.use_mem <= row[0];
      actl.shift   <= 2'(right) + 2'(bottom);
    end
  end

  // channel lanes
  logic [LANES*FIELD_W-1:0] pair_all;
  logic [7:0]               avg_n [LANES];
  logic [7:0]               avg_r [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_avg
    mbd_avg_lane u_avg (
      .cur    (pix[8*i +: 8]),
      .held   (held[8*i +: 8]),
      .stored (mem_rd[FIELD_W*i +: FIELD_W]),
      .ctl    (actl),
      .enable (3'(i) < ch_r),
      .pair   (pair_all[FIELD_W*i +: FIELD_W]),
      .avg    (avg_n[i])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      for (int i = 0; i < LANES; i++) begin
        avg_r[i] <= avg_n[i];
      end
    end
  end

  // top-row pair sums, one entry per output column
  always_ff @(posedge clk) begin
    if (state == ST_SUM && store_r) begin
      mem[addr_r] <= pair_all;
    end
    if (in_acc && proc) begin
      mem_rd <= mem[dx[AW-1:0]];
    end
  end

  // renormalization lanes share the squared length
  norm_ctl_t       nctl;
  logic [SQ_W-1:0] sq [NORM_LANES];
  logic [7:0]      kk [NORM_LANES];
  logic [S_W-1:0]  s_len;

  always_comb begin
    nctl.load     = state == ST_SQ;
    nctl.phase_a  = state == ST_NA;
    nctl.phase_b  = state == ST_NB;
    nctl.bit_mask = 8'h80 >> step;
  end

  for (genvar i = 0; i < NORM_LANES; i++) begin : g_norm
    mbd_norm_lane u_norm (
      .clk (clk),
      .avg (avg_r[i]),
      .ctl (nctl),
      .s   (s_len),
      .sq  (sq[i]),
      .k   (kk[i])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_SSUM) begin
      s_len <= S_W'(sq[0]) + S_W'(sq[1]) + S_W'(sq[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SQ) begin
      step <= '0;
    end else if (state == ST_NB) begin
      step <= step + STEP_W'(1);
    end
  end

  // sequencer
  logic can_load;
  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (!emit_r) state_next = ST_IDLE;
        else if (actl.nm) state_next = ST_SQ;
        else state_next = ST_LOAD;
      end
      ST_SQ:   state_next = ST_SSUM;
      ST_SSUM: state_next = ST_NA;
      ST_NA:   state_next = ST_NB;
      ST_NB:   state_next = (step == '1) ? ST_LOAD : ST_NA;
      ST_LOAD: if (can_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // output register, merges lane results
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_LOAD && can_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && can_load) begin
      m_tlast <= last_r;
      if (actl.nm) begin
        m_tdata <= {avg_r[3], kk[2], kk[1], kk[0]};
      end else begin
        m_tdata <= {avg_r[3], avg_r[2], avg_r[1], avg_r[0]};
      end
    end
  end

  // checks
  `MBD_ASSERT_NXT(a_acc_to_sum, in_acc, state == ST_SUM)
  `MBD_ASSERT_NXT(a_cfg_restart, cfg_hit, col == '0 && row == '0)
  `MBD_ASSERT_NXT(a_search_end, state == ST_NB && step == '1, state == ST_LOAD)
  `MBD_ASSERT_IMP(a_norm_only_nm, state == ST_NA, actl.nm && emit_r)

endmodule

>>> sim/mipmap_box_downscale_tb.sv
module mipmap_box_downscale_tb;
  import mbd_pkg::*;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;    // chan_a, chan_b, chan_c, chan_d
  logic             m_tvalid;
  logic             m_tready;
  logic [31:0]      m_tdata;    // out_a, out_b, out_c, out_d
  logic             m_tlast;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  typedef struct {
    logic [31:0] pix;
    logic        last;
  } out_pix_t;

  logic [31:0] pixel_q[$];
  out_pix_t    avg_q[$];
  int          err_cnt;
  int          src_idle;
  int          snk_stall;
  int          pushed;

  // shadow of the block's registers and state
  logic [CFG_W-1:0] m_width, m_rows;
  logic [2:0]       m_chan;
  logic             m_norm;
  int               pair_sum[MAX_WIDTH_DEF/2][LANES];
  logic [7:0]       held_pix[LANES];
  int               col_cnt, row_cnt;

  mipmap_box_downscale uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  function automatic int to_lin(logic [7:0] v, logic nm);
    return nm ? (int'(v) - 128) * 2 : int'(v);
  endfunction

  // largest k with (2k-255)*sqrt(s) <= 255*x
  function automatic logic [7:0] renorm(longint x, longint s);
    logic [7:0] k;
    logic [7:0] cand;
    longint     m, t;
    logic       ok;
    k = 0;
    for (int b = 7; b >= 0; b--) begin
      cand = k | (8'd1 << b);
      m = 2 * longint'(cand) - 255;
      t = 255 * x;
      if (m < 0) ok = (t >= 0) ? 1'b1 : (m * m * s >= t * t);
      else if (t < 0) ok = 1'b0;
      else ok = (m * m * s <= t * t);
      if (ok) k = cand;
    end
    return k;
  endfunction

  function automatic void apply_cfg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_WIDTH:    m_width = v;
      REG_HEIGHT:   m_rows = v;
      REG_CHANNELS: m_chan = v[2:0];
      REG_NORMAL:   m_norm = v[0];
    endcase
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  // expected output pixel for one accepted source pixel
  function automatic void box_average(logic [31:0] d);
    int         w, h, ch, nw, nh, dx, dy, rc;
    logic       nm, right, bottom, emit;
    int         sum[LANES];
    logic [7:0] cur[LANES];
    logic [7:0] o[LANES];
    longint     x, y, z, s;
    out_pix_t   e;
    w = (m_width < 1) ? 1 : (m_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : m_width;
    h = (m_rows < 1) ? 1 : (m_rows > MAX_HEIGHT) ? MAX_HEIGHT : m_rows;
    ch = (m_chan < 1) ? 1 : (m_chan > 4) ? 4 : m_chan;
    nm = m_norm && ch >= 3;
    nw = (w >> 1) ? (w >> 1) : 1;
    nh = (h >> 1) ? (h >> 1) : 1;
    dx = col_cnt >> 1;
    dy = row_cnt >> 1;
    right = w > 1;
    bottom = h > 1;
    rc = 1;
    emit = 0;
    for (int c = 0; c < LANES; c++) begin
      cur[c] = d[8*c +: 8];
      sum[c] = 0;
    end
    if (!(w == 1 && h == 1) && dx < nw && dy < nh) begin
      if (right && !col_cnt[0]) begin
        held_pix = cur;
      end else begin
        for (int c = 0; c < LANES; c++)
          sum[c] = to_lin(cur[c], nm) + (right ? to_lin(held_pix[c], nm) : 0);
        if (!row_cnt[0] && bottom) begin
          for (int c = 0; c < LANES; c++) pair_sum[dx][c] = sum[c];
        end else begin
          if (row_cnt[0])
            for (int c = 0; c < LANES; c++) sum[c] += pair_sum[dx][c];
          rc = (right ? 2 : 1) * (bottom ? 2 : 1);
          emit = 1;
        end
      end
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
    if (emit) begin
      for (int c = 0; c < LANES; c++)
        o[c] = (c < ch) ? (nm ? 8'(sum[c] / rc / 2 + 128) : 8'(sum[c] / rc)) : 8'd0;
      if (nm) begin
        x = 2 * longint'(o[0]) - 255;
        y = 2 * longint'(o[1]) - 255;
        z = 2 * longint'(o[2]) - 255;
        s = x * x + y * y + z * z;
        o[0] = renorm(x, s);
        o[1] = renorm(y, s);
        o[2] = renorm(z, s);
      end
      e.pix = {o[3], o[2], o[1], o[0]};
      e.last = (dx == nw - 1) && (dy == nh - 1);
      avg_q.insert(avg_q.size(), e);
    end
  endfunction

  // source driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) box_average(s_tdata);
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        s_tvalid <= 1'b1;
        s_tdata <= pixel_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall);
      if (m_tvalid && m_tready) begin
        if (avg_q.size() == 0) begin
          report("unexpected word", m_tdata, 32'h0);
        end else begin
          if (m_tdata !== avg_q[0].pix) report("pixel", m_tdata, avg_q[0].pix);
          if (m_tlast !== avg_q[0].last) report("last", 32'(m_tlast), 32'(avg_q[0].last));
          void'(avg_q.pop_front());
        end
      end
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() != 0 || s_tvalid || avg_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_level(int w, int h, int ch, int nm);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_data <= CFG_W'(w);
    apply_cfg(REG_WIDTH, CFG_W'(w));
    @(posedge clk);
    cfg_index <= REG_HEIGHT; cfg_data <= CFG_W'(h);
    apply_cfg(REG_HEIGHT, CFG_W'(h));
    @(posedge clk);
    cfg_index <= REG_CHANNELS; cfg_data <= CFG_W'(ch);
    apply_cfg(REG_CHANNELS, CFG_W'(ch));
    @(posedge clk);
    cfg_index <= REG_NORMAL; cfg_data <= CFG_W'(nm);
    apply_cfg(REG_NORMAL, CFG_W'(nm));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel(int kind);
    case (kind)
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // a run of n pixels of one kind onto the source queue
  task automatic push_level(int n, int kind);
    for (int i = 0; i < n; i++) pixel_q.insert(pixel_q.size(), rand_pixel(kind));
    pushed += n;
  endtask

  function automatic int sat_w(int v);
    return (v < 1) ? 1 : (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
  endfunction

  initial begin
    int ph, w, h, ch, nm, n, r;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_WIDTH; cfg_data = '0;
    err_cnt = 0; src_idle = 0; snk_stall = 0; pushed = 0;
    m_width = 1; m_rows = 1; m_chan = 4; m_norm = 0;
    col_cnt = 0; row_cnt = 0;
    for (int c = 0; c < LANES; c++) held_pix[c] = 8'h0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default 1x1 level gives nothing
    push_level(2, 3);
    wait_drained();
    // extremes in a 4x2 plain level and a 2x2 normal level
    set_level(4, 2, 4, 0);
    pixel_q.insert(pixel_q.size(), 32'h0); pixel_q.insert(pixel_q.size(), 32'hffff_ffff);
    pixel_q.insert(pixel_q.size(), 32'hffff_ffff); pixel_q.insert(pixel_q.size(), 32'h0);
    push_level(4, 1);
    wait_drained();
    set_level(2, 2, 3, 1);
    push_level(4, 0);
    wait_drained();
    // normal mode with too few channels averages plainly
    set_level(2, 2, 2, 1);
    push_level(4, 3);
    wait_drained();
    // single column, single row, odd trailing column and row
    set_level(1, 4, 1, 0);
    push_level(4, 3);
    wait_drained();
    set_level(4, 1, 0, 0);
    push_level(4, 3);
    wait_drained();
    set_level(3, 3, 7, 1);
    push_level(9, 3);
    wait_drained();
    // wide and tall levels, partly fed, out-of-range sizes saturate
    set_level(8191, 0, 5, 0);
    push_level(24, 3);
    wait_drained();
    set_level(1, 0, 4, 1);
    push_level(1, 3);
    wait_drained();
    set_level(1, 4096, 3, 1);
    push_level(16, 3);
    wait_drained();

    // random levels, cycling the idle modes
    ph = 0;
    while (pushed < 1000) begin
      case (ph % 4)
        0: begin src_idle = 0; snk_stall = 0; end
        1: begin src_idle = 49; snk_stall = 0; end
        2: begin src_idle = 0; snk_stall = 49; end
        default: begin src_idle = 24; snk_stall = 24; end
      endcase
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      ch = $urandom_range(0, 7);
      nm = $urandom_range(1);
      r = $urandom_range(19);
      if (r == 0) w = 0;
      else if (r == 1) h = 0;
      n = sat_w(w) * sat_w(h);
      set_level(w, h, ch, nm);
      if (ph == 5) begin
        // hold off until everything has drained, then finish the level
        push_level(n / 2, 3);
        while (pixel_q.size() != 0 || s_tvalid || avg_q.size() != 0) @(posedge clk);
        push_level(n - n / 2, 3);
      end else begin
        push_level(n, ($urandom_range(9) == 0) ? 2 : 3);
        if ($urandom_range(4) == 0) push_level($urandom_range(1, 5), 3);
      end
      wait_drained();
      ph++;
    end

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("FAIL");
    $finish;
  end

endmodule
